### rtl/core/wri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wri_pkg: shared types and constants for the weighted regression intercept
// Sum widths, the sum snapshot passed from the accumulator to the solver,
// the result record and the solver state encoding.
// ----------------------------------------------------------------------------
package wri_pkg;

  // Running sum widths.
  localparam int SW_W   = 28;
  localparam int SWX_W  = 44;
  localparam int SWY_W  = 44;
  localparam int SWXX_W = 58;
  localparam int SWXY_W = 60;

  // Solver datapath widths.
  localparam int MUL_A_W = 60;   // widest multiplicand (Swxy magnitude)
  localparam int MUL_B_W = 64;   // multiplier, taken one 16-bit digit a step
  localparam int DIG_W   = 16;
  localparam int PROD_W  = MUL_A_W + DIG_W;
  localparam int ACC_W   = 104;  // product accumulator
  localparam int NUM_W   = 104;  // signed numerator
  localparam int DEN_W   = 88;   // signed denominator
  localparam int NMAG_W  = 103;  // numerator magnitude
  localparam int DMAG_W  = 87;   // denominator magnitude
  localparam int QUO_W   = 33;   // quotient bits produced by the divider
  localparam int STEP_W  = 6;

  // Queue between the accumulator and the solver.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Saturation values of the Q16.16 result.
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // Quotient limits for each result sign.
  localparam logic [QUO_W-1:0] QLIM_POS = 33'h0_7FFF_FFFF;
  localparam logic [QUO_W-1:0] QLIM_NEG = 33'h0_8000_0000;

  // Product codes of the shared multiplier.
  localparam logic [1:0] PR_XX_Y  = 2'd0;
  localparam logic [1:0] PR_XY_X  = 2'd1;
  localparam logic [1:0] PR_XX_W  = 2'd2;
  localparam logic [1:0] PR_X_X   = 2'd3;

  typedef struct packed {
    logic [SW_W-1:0]   sw;
    logic [SWX_W-1:0]  swx;
    logic [SWY_W-1:0]  swy;
    logic [SWXX_W-1:0] swxx;
    logic [SWXY_W-1:0] swxy;
  } sums_t;

  typedef struct packed {
    logic [31:0] intercept;
    logic        singular;
    logic        saturated;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FOLD,
    ST_ABS,
    ST_PRE,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### rtl/core/wri_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wri_acc: point accumulator front end
// Takes one point a cycle unless stalled, forms the weighted products in two
// multiplier stages and adds them into the five running sums. A closing point
// pushes the finished sums into the queue and restarts the sums from zero.
// ----------------------------------------------------------------------------
module wri_acc #(
  parameter int MAX_POINTS = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pt_valid,
  output logic                pt_ready,
  input  logic signed [15:0]  x_value,
  input  logic signed [15:0]  y_value,
  input  logic [15:0]         weight,
  input  logic                last_point,
  output logic                push_valid,
  input  logic                push_ready,
  output wri_pkg::sums_t      push_sums
);
  import wri_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               advance, accept, close_in;

  logic               s1_valid_r, s1_close_r;
  logic signed [15:0] s1_x_r, s1_y_r;
  logic [15:0]        s1_w_r;
  logic signed [31:0] s1_wx_r, s1_wy_r;

  logic               s2_valid_r, s2_close_r;
  logic [15:0]        s2_w_r;
  logic signed [31:0] s2_wx_r, s2_wy_r;
  logic signed [47:0] s2_wxx_r, s2_wxy_r;

  logic signed [32:0] wx_full, wy_full;
  logic signed [47:0] wxx_full, wxy_full;

  sums_t              sum_r, sum_add;

  // The pipeline only stops when a closing point cannot enter the queue.
  assign advance  = !(s2_valid_r && s2_close_r && !push_ready);
  assign pt_ready = advance;
  assign accept   = pt_valid && advance;

  // A set closes on the marked point or when it reaches the point limit.
  assign close_in = last_point || (cnt_r == CNT_W'(MAX_POINTS - 1));

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = close_in ? '0 : cnt_r + CNT_W'(1);
    end
  end

  // First multiplier stage: weight times x and weight times y.
  assign wx_full = $signed({1'b0, weight}) * x_value;
  assign wy_full = $signed({1'b0, weight}) * y_value;

  // Second multiplier stage: (w*x) times x and (w*x) times y.
  assign wxx_full = s1_wx_r * s1_x_r;
  assign wxy_full = s1_wx_r * s1_y_r;

  // Sums including the point in the last stage; each wraps at its width.
  always_comb begin
    sum_add.sw   = sum_r.sw + SW_W'(s2_w_r);
    sum_add.swx  = sum_r.swx + {{(SWX_W-32){s2_wx_r[31]}}, s2_wx_r};
    sum_add.swy  = sum_r.swy + {{(SWY_W-32){s2_wy_r[31]}}, s2_wy_r};
    sum_add.swxx = sum_r.swxx + {{(SWXX_W-48){s2_wxx_r[47]}}, s2_wxx_r};
    sum_add.swxy = sum_r.swxy + {{(SWXY_W-48){s2_wxy_r[47]}}, s2_wxy_r};
  end

  assign push_valid = s2_valid_r && s2_close_r;
  assign push_sums  = sum_add;

  // Control state and the running sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_close_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s2_close_r <= 1'b0;
      sum_r      <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (advance) begin
        s1_valid_r <= accept;
        s1_close_r <= close_in;
        s2_valid_r <= s1_valid_r;
        s2_close_r <= s1_close_r;
        if (s2_valid_r) begin
          sum_r <= s2_close_r ? '0 : sum_add;
        end
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_x_r   <= x_value;
      s1_y_r   <= y_value;
      s1_w_r   <= weight;
      s1_wx_r  <= wx_full[31:0];
      s1_wy_r  <= wy_full[31:0];
      s2_w_r   <= s1_w_r;
      s2_wx_r  <= s1_wx_r;
      s2_wy_r  <= s1_wy_r;
      s2_wxx_r <= wxx_full;
      s2_wxy_r <= wxy_full;
    end
  end

endmodule

### rtl/core/wri_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wri_fifo: sum snapshot queue
// A two-entry queue of finished sum sets between the accumulator and the
// solver, so that either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module wri_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  wri_pkg::sums_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output wri_pkg::sums_t rd_data
);
  import wri_pkg::*;

  sums_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_wr, do_rd;

  assign wr_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/core/wri_solve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wri_solve: intercept solver back end
// Takes one sum set from the queue, forms numerator and denominator with a
// shared 60x16 multiplier one digit per cycle, then runs a restoring divider
// one quotient bit per cycle and saturates the Q16.16 result.
// ----------------------------------------------------------------------------
module wri_solve (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  wri_pkg::sums_t   q_sums,
  output logic             res_valid,
  input  logic             res_ready,
  output wri_pkg::result_t res
);
  import wri_pkg::*;

  state_t               state_r, state_nxt;

  // Split sums: magnitudes and signs.
  logic [SW_W-1:0]      mw_r, mw_nxt;
  logic [SWXX_W-1:0]    mxx_r, mxx_nxt;
  logic [SWX_W-1:0]     mx_r, mx_nxt;
  logic [SWY_W-1:0]     my_r, my_nxt;
  logic [SWXY_W-1:0]    mxy_r, mxy_nxt;
  logic                 nx_r, nx_nxt, ny_r, ny_nxt, nxy_r, nxy_nxt;

  // Multiplier sequencing.
  logic [1:0]           k_r, k_nxt, dig_r, dig_nxt;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [DIG_W-1:0]     mul_d;
  logic [PROD_W-1:0]    prod;
  logic [ACC_W-1:0]     acc_r, acc_nxt;

  // Numerator, denominator and divider.
  logic signed [NUM_W-1:0] num_r, num_nxt;
  logic signed [DEN_W-1:0] den_r, den_nxt;
  logic [NMAG_W-1:0]    nmag_r, nmag_nxt;
  logic [DMAG_W-1:0]    dmag_r, dmag_nxt;
  logic                 nneg_r, nneg_nxt, dneg_r, dneg_nxt;
  logic                 sing_r, sing_nxt, sat_r, sat_nxt;
  logic [DMAG_W-1:0]    rem_r, rem_nxt;
  logic [QUO_W-1:0]     nsh_r, nsh_nxt, quo_r, quo_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [DMAG_W:0]      trial;
  logic [DMAG_W:0]      trial_diff;
  logic signed [NUM_W-1:0] acc_s;
  logic signed [NUM_W-1:0] num_neg;
  logic signed [DEN_W-1:0] den_neg;

  // Result assembly and output register.
  logic                 qneg, q_over;
  result_t              fin;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_res_r, out_res_nxt;

  assign q_ready   = (state_r == ST_IDLE);
  assign res_valid = out_valid_r;
  assign res       = out_res_r;

  // Operand selection of the shared multiplier, most significant digit first.
  always_comb begin
    case (k_r)
      PR_XX_Y: begin
        mul_a = MUL_A_W'(mxx_r);
        mul_b = MUL_B_W'(my_r);
      end
      PR_XY_X: begin
        mul_a = mxy_r;
        mul_b = MUL_B_W'(mx_r);
      end
      PR_XX_W: begin
        mul_a = MUL_A_W'(mxx_r);
        mul_b = MUL_B_W'(mw_r);
      end
      PR_X_X: begin
        mul_a = MUL_A_W'(mx_r);
        mul_b = MUL_B_W'(mx_r);
      end
      default: begin
        mul_a = MUL_A_W'(mxx_r);
        mul_b = MUL_B_W'(my_r);
      end
    endcase
    case (dig_r)
      2'd0:    mul_d = mul_b[63:48];
      2'd1:    mul_d = mul_b[47:32];
      2'd2:    mul_d = mul_b[31:16];
      2'd3:    mul_d = mul_b[15:0];
      default: mul_d = mul_b[15:0];
    endcase
  end

  assign prod    = mul_a * mul_d;
  assign acc_s   = $signed(acc_r);
  assign num_neg = -num_r;
  assign den_neg = -den_r;

  // One restoring division step.
  assign trial      = {rem_r, nsh_r[QUO_W-1]};
  assign trial_diff = trial - {1'b0, dmag_r};

  // Final sign, saturation and result record.
  assign qneg   = nneg_r ^ dneg_r;
  assign q_over = qneg ? (quo_r > QLIM_NEG) : (quo_r > QLIM_POS);

  always_comb begin
    fin = '0;
    if (sing_r) begin
      fin.singular = 1'b1;
    end else if (sat_r || q_over) begin
      fin.intercept = qneg ? SAT_NEG : SAT_POS;
      fin.saturated = 1'b1;
    end else begin
      fin.intercept = qneg ? -quo_r[31:0] : quo_r[31:0];
    end
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    mw_nxt        = mw_r;
    mxx_nxt       = mxx_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    mxy_nxt       = mxy_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    nxy_nxt       = nxy_r;
    k_nxt         = k_r;
    dig_nxt       = dig_r;
    acc_nxt       = acc_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    nmag_nxt      = nmag_r;
    dmag_nxt      = dmag_r;
    nneg_nxt      = nneg_r;
    dneg_nxt      = dneg_r;
    sing_nxt      = sing_r;
    sat_nxt       = sat_r;
    rem_nxt       = rem_r;
    nsh_nxt       = nsh_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && res_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        // Take a sum set and split the signed sums into sign and magnitude.
        if (q_valid) begin
          mw_nxt    = q_sums.sw;
          mxx_nxt   = q_sums.swxx;
          nx_nxt    = q_sums.swx[SWX_W-1];
          ny_nxt    = q_sums.swy[SWY_W-1];
          nxy_nxt   = q_sums.swxy[SWXY_W-1];
          mx_nxt    = q_sums.swx[SWX_W-1] ? -q_sums.swx : q_sums.swx;
          my_nxt    = q_sums.swy[SWY_W-1] ? -q_sums.swy : q_sums.swy;
          mxy_nxt   = q_sums.swxy[SWXY_W-1] ? -q_sums.swxy : q_sums.swxy;
          k_nxt     = PR_XX_Y;
          dig_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // Shift-and-add one 16-bit digit of the multiplier.
        acc_nxt = (acc_r << DIG_W) + ACC_W'(prod);
        dig_nxt = dig_r + 2'd1;
        if (dig_r == 2'd3) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        // Fold the finished product into numerator or denominator.
        case (k_r)
          PR_XX_Y: num_nxt = ny_r ? -acc_s : acc_s;
          PR_XY_X: num_nxt = (nx_r ^ nxy_r) ? num_r + acc_s : num_r - acc_s;
          PR_XX_W: den_nxt = $signed(acc_r[DEN_W-1:0]);
          PR_X_X:  den_nxt = den_r - $signed(acc_r[DEN_W-1:0]);
          default: num_nxt = num_r;
        endcase
        acc_nxt = '0;
        dig_nxt = '0;
        k_nxt   = k_r + 2'd1;
        state_nxt = (k_r == PR_X_X) ? ST_ABS : ST_MUL;
      end
      ST_ABS: begin
        // Magnitudes and the singular check.
        nneg_nxt  = num_r[NUM_W-1];
        dneg_nxt  = den_r[DEN_W-1];
        nmag_nxt  = num_r[NUM_W-1] ? num_neg[NMAG_W-1:0] : num_r[NMAG_W-1:0];
        dmag_nxt  = den_r[DEN_W-1] ? den_neg[DMAG_W-1:0] : den_r[DMAG_W-1:0];
        sing_nxt  = (den_r == '0);
        sat_nxt   = 1'b0;
        state_nxt = (den_r == '0) ? ST_DONE : ST_PRE;
      end
      ST_PRE: begin
        // The numerator is scaled by 256; a quotient of 2^33 or more saturates.
        sat_nxt   = (DMAG_W'(nmag_r[NMAG_W-1:25]) >= dmag_r);
        rem_nxt   = DMAG_W'(nmag_r[NMAG_W-1:25]);
        nsh_nxt   = {nmag_r[24:0], 8'b0};
        quo_nxt   = '0;
        step_nxt  = '0;
        state_nxt = (DMAG_W'(nmag_r[NMAG_W-1:25]) >= dmag_r) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        // One quotient bit per cycle.
        if (!trial_diff[DMAG_W]) begin
          rem_nxt = trial_diff[DMAG_W-1:0];
          quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DMAG_W-1:0];
          quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
        end
        nsh_nxt  = nsh_r << 1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(QUO_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || res_ready) begin
          out_res_nxt   = fin;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mw_r      <= mw_nxt;
    mxx_r     <= mxx_nxt;
    mx_r      <= mx_nxt;
    my_r      <= my_nxt;
    mxy_r     <= mxy_nxt;
    nx_r      <= nx_nxt;
    ny_r      <= ny_nxt;
    nxy_r     <= nxy_nxt;
    k_r       <= k_nxt;
    dig_r     <= dig_nxt;
    acc_r     <= acc_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    nmag_r    <= nmag_nxt;
    dmag_r    <= dmag_nxt;
    nneg_r    <= nneg_nxt;
    dneg_r    <= dneg_nxt;
    sing_r    <= sing_nxt;
    sat_r     <= sat_nxt;
    rem_r     <= rem_nxt;
    nsh_r     <= nsh_nxt;
    quo_r     <= quo_nxt;
    step_r    <= step_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

### rtl/core/weighted_regression_intercept.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_regression_intercept: weighted least-squares intercept
// Accumulates weighted sums over a set of points and gives the intercept
// (Swxx*Swy - Swx*Swxy) / (Sw*Swxx - Swx^2) in Q16.16 for each closed set.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Transaction carries
//   in_      input      one point: x, y, weight; tlast closes the set
//   out_     output     one result per set: intercept; tuser flags
//
// The accumulator takes one point per cycle; a closing point's sums enter the queue from
// its second multiplier stage. The solver does one set at a time: four products of four
// digits plus a fold each in the shared 60x16 multiplier, then the one-bit restoring
// divider for 33 quotient bits, with take, sign split, divider setup and hand-off as
// separate steps. The input stalls only while a closing point finds both queue entries
// full. Reset is synchronous; after it all sums are zero and no result is pending.
// ----------------------------------------------------------------------------
module weighted_regression_intercept #(
  parameter int MAX_POINTS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // x_value [15:0], y_value [31:16], weight [47:32]
  input  logic        in_tlast,   // last_point
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // intercept [31:0]
  output logic [1:0]  out_tuser   // singular [0], saturated [1]
);
  import wri_pkg::*;

  logic    push_valid, push_ready;
  sums_t   push_sums;
  logic    q_valid, q_ready;
  sums_t   q_sums;
  result_t res;

  wri_acc #(
    .MAX_POINTS(MAX_POINTS)
  ) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .pt_valid   (in_tvalid),
    .pt_ready   (in_tready),
    .x_value    (in_tdata[15:0]),
    .y_value    (in_tdata[31:16]),
    .weight     (in_tdata[47:32]),
    .last_point (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_sums  (push_sums)
  );

  wri_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_sums),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_sums)
  );

  wri_solve u_solve (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_sums    (q_sums),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = res.intercept;
  assign out_tuser = {res.saturated, res.singular};

endmodule

### rtl/core/wri_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wri_check: port-level checks for the weighted regression intercept
// Watches the top-level ports for result encoding and handshake rules.
// ----------------------------------------------------------------------------
module wri_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import wri_pkg::*;

  // A waiting point holds its value until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tlast))
    else $error("point changed while waiting");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A singular set reads zero and is never marked saturated.
  a_singular: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("singular result not zero");

  // A saturated result sits at one of the two range limits.
  a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == SAT_POS || out_tdata == SAT_NEG)
    else $error("saturated result not at a limit");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind weighted_regression_intercept wri_check u_wri_check (.*);

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the weighted regression intercept
// Streams sets of weighted points into the block and predicts each set's
// Q16.16 intercept with exact wide integer arithmetic. Every result
// transaction is compared field by field against the oldest prediction.
// Both stream sides pause at random, and a watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module testbench;
  import wri_pkg::*;

  localparam int SET_LIMIT      = 4096;
  localparam int CLK_HALF_NS    = 6;
  localparam int RESET_CYCLES   = 4;
  localparam int MAX_WAIT       = 12;
  localparam int RANDOM_POINTS  = 680;
  localparam int TAIL_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 4000;

  // One point as it travels on the input stream.
  typedef struct packed {
    logic [15:0] x_value;
    logic [15:0] y_value;
    logic [15:0] weight;
    logic        last_point;
  } point_t;

  // Running weighted sums, the intercept predictor and the queue of
  // intercepts still to come out of the block.
  class intercept_scoreboard;
    logic [SW_W-1:0]   sum_w;
    logic [SWX_W-1:0]  sum_wx;
    logic [SWY_W-1:0]  sum_wy;
    logic [SWXX_W-1:0] sum_wxx;
    logic [SWXY_W-1:0] sum_wxy;
    int unsigned       points_in_set;
    result_t           intercept_q[$];
    int unsigned       error_count;

    function new();
      clear_sums();
      error_count = 0;
    endfunction

    function void clear_sums();
      sum_w         = '0;
      sum_wx        = '0;
      sum_wy        = '0;
      sum_wxx       = '0;
      sum_wxy       = '0;
      points_in_set = 0;
    endfunction

    function int unsigned pending();
      return intercept_q.size();
    endfunction

    // Accumulate one accepted point; a closed set yields one intercept.
    function void note_point(point_t p);
      logic signed [63:0]  xs, ys, ws, wx;
      logic signed [127:0] sw_e, swx_e, swy_e, swxx_e, swxy_e, num, den;
      logic [127:0]        nmag, dmag, quo, lim;
      logic                nneg, dneg, qneg;
      result_t             res;
      xs = $signed(p.x_value);
      ys = $signed(p.y_value);
      ws = {48'd0, p.weight};
      wx = ws * xs;
      // Each sum wraps at its own width.
      sum_w   = sum_w + p.weight;
      sum_wx  = sum_wx + wx;
      sum_wy  = sum_wy + ws * ys;
      sum_wxx = sum_wxx + wx * xs;
      sum_wxy = sum_wxy + wx * ys;
      points_in_set++;
      if (!p.last_point && points_in_set < SET_LIMIT) return;

      sw_e   = {100'd0, sum_w};
      swxx_e = {70'd0, sum_wxx};
      swx_e  = $signed(sum_wx);
      swy_e  = $signed(sum_wy);
      swxy_e = $signed(sum_wxy);
      clear_sums();
      num = swxx_e * swy_e - swx_e * swxy_e;
      den = sw_e * swxx_e - swx_e * swx_e;

      res = '0;
      if (den == 0) begin
        res.singular = 1'b1;
      end else begin
        // Divide magnitudes with eight extra fraction bits, truncating.
        nneg = num[127];
        dneg = den[127];
        nmag = nneg ? -num : num;
        dmag = dneg ? -den : den;
        nmag = nmag << 8;
        quo  = nmag / dmag;
        qneg = nneg ^ dneg;
        lim  = qneg ? {96'd0, SAT_NEG} : {96'd0, SAT_POS};
        if (quo > lim) begin
          res.intercept = qneg ? SAT_NEG : SAT_POS;
          res.saturated = 1'b1;
        end else begin
          res.intercept = qneg ? -quo[31:0] : quo[31:0];
        end
      end
      intercept_q.push_back(res);
    endfunction

    // Compare one result transaction against the oldest prediction.
    function void check_result(result_t got);
      result_t want;
      if (intercept_q.size() == 0) begin
        $display("%0t: unexpected result intercept %h singular %b saturated %b",
                 $time, got.intercept, got.singular, got.saturated);
        error_count++;
        return;
      end
      want = intercept_q.pop_front();
      if (got.intercept !== want.intercept) begin
        $display("%0t: intercept expected %h actual %h",
                 $time, want.intercept, got.intercept);
        error_count++;
      end
      if (got.singular !== want.singular) begin
        $display("%0t: singular expected %b actual %b",
                 $time, want.singular, got.singular);
        error_count++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %b actual %b",
                 $time, want.saturated, got.saturated);
        error_count++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // x_value [15:0], y_value [31:16], weight [47:32]
  logic        in_tlast   = 1'b0; // last_point
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // intercept [31:0]
  logic [1:0]  out_tuser;         // singular [0], saturated [1]

  intercept_scoreboard regression_sb = new();
  int unsigned         idle_cycles   = 0;
  bit                  sender_steady = 1'b0;
  bit                  sink_steady   = 1'b0;

  weighted_regression_intercept #(
    .MAX_POINTS(SET_LIMIT)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock generation.
  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // Draw a wait before a transaction; steady stretches draw no waits.
  function automatic int unsigned draw_wait(inout bit steady);
    if ($urandom_range(0, 99) < 4) steady = !steady;
    return steady ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Present one point and hold it until the block takes it.
  task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] w, input logic last);
    int unsigned gap;
    gap = draw_wait(sender_steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w, y, x};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold off the sender until every predicted intercept has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (regression_sb.pending() != 0) @(posedge clk);
  endtask

  // Monitor both channels and watch for a stalled run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        regression_sb.note_point({in_tdata[15:0], in_tdata[31:16], in_tdata[47:32],
                                  in_tlast});
      if (out_tvalid && out_tready)
        regression_sb.check_result({out_tdata, out_tuser[0], out_tuser[1]});
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("weighted_regression_intercept: mismatch");
        $finish;
      end
    end
  end

  // Result sink with random back-pressure.
  initial begin
    int unsigned stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(sink_steady);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Stimulus: directed sets, then random sets.
  initial begin
    int unsigned sent;
    int unsigned set_kind;
    int unsigned set_len;
    logic [15:0] base_x;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic        last;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A single point leaves a zero denominator.
    send_point(16'h7FFF, 16'h8000, 16'hFFFF, 1'b1);
    // All weights zero.
    send_point(16'h1234, 16'h4321, 16'h0000, 1'b0);
    send_point(16'h8000, 16'h7FFF, 16'h0000, 1'b1);
    // Identical x values with different y.
    send_point(16'h0100, 16'h0200, 16'h4000, 1'b0);
    send_point(16'h0100, 16'hFE00, 16'h8000, 1'b1);
    // A steep line through nearly equal x values drives the intercept
    // past the negative limit, then past the positive one.
    send_point(16'h7FFF, 16'h7FFF, 16'h8000, 1'b0);
    send_point(16'h7FFE, 16'h8000, 16'h8000, 1'b1);
    send_point(16'h7FFF, 16'h8000, 16'hFFFF, 1'b0);
    send_point(16'h7FFE, 16'h7FFF, 16'hFFFF, 1'b1);
    // Field extremes on a well-conditioned set.
    send_point(16'h8000, 16'h8000, 16'hFFFF, 1'b0);
    send_point(16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0);
    send_point(16'h0000, 16'h0000, 16'h0001, 1'b1);
    // Ordinary three-point set with a nonzero intercept.
    send_point(16'hFF00, 16'h0280, 16'h8000, 1'b0);
    send_point(16'h0100, 16'h0480, 16'h2000, 1'b0);
    send_point(16'h0300, 16'h0900, 16'h6000, 1'b1);
    drain_results();

    sent = 0;
    while (sent < RANDOM_POINTS) begin
      set_kind = $urandom_range(0, 9);
      set_len  = (set_kind == 9) ? 1 : $urandom_range(1, 8);
      base_x   = 16'($urandom);
      for (int k = 0; k < set_len; k++) begin
        case (set_kind)
          // Clustered x values: near-singular and saturating sets.
          6, 7: x = base_x + 16'($urandom_range(0, 4)) - 16'd2;
          // Small magnitudes keep the intercept in range.
          5: x = 16'($urandom_range(0, 1023)) - 16'd512;
          default: x = 16'($urandom);
        endcase
        y    = (set_kind == 5) ? 16'($urandom_range(0, 1023)) - 16'd512 : 16'($urandom);
        w    = (set_kind == 8 && $urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
        last = (set_kind == 4) ? ($urandom_range(0, 3) == 0) : (k == set_len - 1);
        send_point(x, y, w, last);
        sent++;
      end
      if ($urandom_range(0, 29) == 0) drain_results();
    end
    // Close whatever set is still open.
    send_point(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    in_tvalid <= 1'b0;

    // Wait out the remaining results, then watch for stray ones.
    @(posedge clk);
    while (regression_sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (regression_sb.error_count == 0 && regression_sb.pending() == 0)
      $display("weighted_regression_intercept: match");
    else
      $display("weighted_regression_intercept: mismatch");
    $finish;
  end

endmodule
